// File: rtl/core/ave_pkg.sv
// Shared constants and the item type passed from the front end to the back end.
package ave_pkg;

	localparam int Channels = 4;
	localparam int ChIdxW = (Channels > 1) ? $clog2(Channels) : 1;

	localparam int NumW = 52;
	localparam int DivSteps = NumW;
	localparam int CntW = $clog2(DivSteps);

	localparam int QDepth = 2;
	localparam int QPtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
	localparam int QCntW = $clog2(QDepth + 1);

	localparam logic [3:0] CfgGainBase = 4'd0;
	localparam logic [3:0] CfgOffsetBase = 4'd4;
	localparam logic [3:0] CfgLimit = 4'd8;

	localparam logic signed [31:0] GainReset = 32'sd65536;
	localparam logic signed [53:0] MsPerS = 54'sd1000;

	typedef struct packed {
		logic [1:0]         channel;
		logic [10:0]        sample;
		logic signed [31:0] gain;
		logic signed [31:0] offset;
		logic [31:0]        elapsed;
		logic signed [11:0] diff;
		logic               vel_en;
	} ave_item_t;

endpackage

// File: rtl/core/adc_angle_velocity_estimator.sv
// Top level of the ADC angle and velocity estimator.
// Each item is queued, popped, multiplied, scaled, divided and registered at the output.
// When velocity is flagged invalid, the divider is skipped.
// The restoring divider yields one bit per cycle; the back end pops items only when idle.
// A two-entry queue lets the input take items while a result waits at the output.
// Reset clears the gains to 1.0, the offsets and channel history to zero, and all handshakes.
module adc_angle_velocity_estimator (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         channel,
	input  logic [10:0]        sample,
	input  logic [31:0]        time_ms,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         out_channel,
	output logic signed [43:0] position,
	output logic signed [52:0] velocity,
	output logic               velocity_valid,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [3:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	logic q_full;
	logic q_empty;
	logic q_push;
	logic q_pop;
	ave_pkg::ave_item_t push_item;
	ave_pkg::ave_item_t pop_item;

	ave_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.channel   (channel),
		.sample    (sample),
		.time_ms   (time_ms),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_item    (push_item)
	);

	ave_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.pop_item  (pop_item),
		.empty     (q_empty)
	);

	ave_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_empty        (q_empty),
		.q_item         (pop_item),
		.q_pop          (q_pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_channel    (out_channel),
		.position       (position),
		.velocity       (velocity),
		.velocity_valid (velocity_valid)
	);

endmodule

// File: rtl/core/ave_front.sv
// Front end: configuration registers, per-channel history and item classification.
module ave_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [1:0]            channel,
	input  logic [10:0]           sample,
	input  logic [31:0]           time_ms,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [3:0]            cfg_index,
	input  logic [31:0]           cfg_data,
	input  logic                  q_full,
	output logic                  q_push,
	output ave_pkg::ave_item_t    q_item
);

	logic signed [31:0] gain_q [4];
	logic signed [31:0] offset_q [4];
	logic [10:0] last_sample_q [ave_pkg::Channels];
	logic [31:0] last_time_q [ave_pkg::Channels];

	logic [ave_pkg::ChIdxW-1:0] st_idx;
	logic in_range;
	logic accept;
	logic [31:0] elapsed;

	assign cfg_ready = 1'b1;
	assign in_stall = q_full;
	assign accept = in_valid && !q_full;
	assign q_push = accept;
	assign st_idx = channel[ave_pkg::ChIdxW-1:0];
	assign in_range = int'(channel) < ave_pkg::Channels;
	assign elapsed = time_ms - last_time_q[st_idx];

	always_comb begin
		q_item.channel = channel;
		q_item.sample = sample;
		q_item.gain = gain_q[channel];
		q_item.offset = offset_q[channel];
		q_item.elapsed = elapsed;
		q_item.diff = $signed({1'b0, sample}) - $signed({1'b0, last_sample_q[st_idx]});
		q_item.vel_en = in_range && (elapsed != 32'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				gain_q[i] <= ave_pkg::GainReset;
				offset_q[i] <= '0;
			end
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index < ave_pkg::CfgOffsetBase) begin
				gain_q[cfg_index[1:0]] <= cfg_data;
			end else if (cfg_index < ave_pkg::CfgLimit) begin
				offset_q[cfg_index[1:0]] <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ave_pkg::Channels; i++) begin
				last_sample_q[i] <= '0;
				last_time_q[i] <= '0;
			end
		end else if (accept && in_range) begin
			last_sample_q[st_idx] <= sample;
			last_time_q[st_idx] <= time_ms;
		end
	end

endmodule

// File: rtl/core/ave_queue.sv
// Short queue that decouples the front end from the back end.
module ave_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  ave_pkg::ave_item_t push_item,
	output logic               full,
	input  logic               pop,
	output ave_pkg::ave_item_t pop_item,
	output logic               empty
);

	ave_pkg::ave_item_t entry_q [ave_pkg::QDepth];
	logic [ave_pkg::QPtrW-1:0] wr_ptr_q;
	logic [ave_pkg::QPtrW-1:0] rd_ptr_q;
	logic [ave_pkg::QCntW-1:0] count_q;

	assign full = count_q == ave_pkg::QCntW'(ave_pkg::QDepth);
	assign empty = count_q == '0;
	assign pop_item = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= (int'(wr_ptr_q) == ave_pkg::QDepth - 1) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop && !empty) begin
				rd_ptr_q <= (int'(rd_ptr_q) == ave_pkg::QDepth - 1) ? '0 : rd_ptr_q + 1'b1;
			end
			if ((push && !full) && !(pop && !empty)) begin
				count_q <= count_q + 1'b1;
			end else if (!(push && !full) && (pop && !empty)) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		int'(count_q) <= ave_pkg::QDepth)
		else $error("queue count exceeds depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full && !pop) |=> !empty)
		else $error("queue empty after a push");

	assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> (wr_ptr_q == rd_ptr_q))
		else $error("queue pointers differ while empty");

endmodule

// File: rtl/core/ave_back.sv
// Back end: position and velocity arithmetic with a bit-serial divider and output register.
module ave_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      q_empty,
	input  ave_pkg::ave_item_t        q_item,
	output logic                      q_pop,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [1:0]                out_channel,
	output logic signed [43:0]        position,
	output logic signed [52:0]        velocity,
	output logic                      velocity_valid
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_SCALE,
		S_DIV,
		S_DONE
	} state_t;

	state_t state_q;
	ave_pkg::ave_item_t item_q;
	logic signed [43:0] pos_q;
	logic signed [43:0] prod_q;
	logic neg_q;
	logic [31:0] rem_q;
	logic [ave_pkg::NumW-1:0] quo_q;
	logic [ave_pkg::CntW-1:0] cnt_q;

	logic out_valid_q;
	logic [1:0] out_channel_q;
	logic signed [43:0] position_q;
	logic signed [52:0] velocity_q;
	logic velocity_valid_q;

	logic signed [43:0] pos_mul;
	logic signed [43:0] diff_mul;
	logic signed [53:0] num;
	logic [53:0] num_mag;
	logic [32:0] rem_sh;
	logic [32:0] rem_sub;
	logic out_free;
	logic [52:0] quo_ext;

	assign q_pop = (state_q == S_IDLE) && !q_empty;
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		pos_mul = $signed({1'b0, item_q.sample}) * item_q.gain;
		diff_mul = item_q.diff * item_q.gain;
		num = {{10{prod_q[43]}}, prod_q} * ave_pkg::MsPerS;
		num_mag = num[53] ? 54'(-num) : 54'(num);
		rem_sh = {rem_q, quo_q[ave_pkg::NumW-1]};
		rem_sub = rem_sh - {1'b0, item_q.elapsed};
		quo_ext = {1'b0, quo_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			item_q <= '0;
			pos_q <= '0;
			prod_q <= '0;
			neg_q <= 1'b0;
			rem_q <= '0;
			quo_q <= '0;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
			out_channel_q <= '0;
			position_q <= '0;
			velocity_q <= '0;
			velocity_valid_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (!q_empty) begin
						item_q <= q_item;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					pos_q <= pos_mul + {{12{item_q.offset[31]}}, item_q.offset};
					prod_q <= diff_mul;
					state_q <= S_SCALE;
				end
				S_SCALE: begin
					rem_q <= '0;
					cnt_q <= '0;
					if (item_q.vel_en) begin
						neg_q <= num[53];
						quo_q <= num_mag[ave_pkg::NumW-1:0];
						state_q <= S_DIV;
					end else begin
						neg_q <= 1'b0;
						quo_q <= '0;
						state_q <= S_DONE;
					end
				end
				S_DIV: begin
					if (!rem_sub[32]) begin
						rem_q <= rem_sub[31:0];
						quo_q <= {quo_q[ave_pkg::NumW-2:0], 1'b1};
					end else begin
						rem_q <= rem_sh[31:0];
						quo_q <= {quo_q[ave_pkg::NumW-2:0], 1'b0};
					end
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == ave_pkg::CntW'(ave_pkg::DivSteps - 1)) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_channel_q <= item_q.channel;
						position_q <= pos_q;
						velocity_q <= neg_q ? 53'(-quo_ext) : quo_ext;
						velocity_valid_q <= item_q.vel_en;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_channel = out_channel_q;
	assign position = position_q;
	assign velocity = velocity_q;
	assign velocity_valid = velocity_valid_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !velocity_valid) |-> (velocity == '0))
		else $error("nonzero velocity on an invalid result");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (item_q.elapsed != 32'd0))
		else $error("divider running with a zero divisor");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && cnt_q == ave_pkg::CntW'(ave_pkg::DivSteps - 1)) |=>
		(state_q == S_DONE))
		else $error("divider did not finish after its last step");

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> ($past(state_q) == S_DONE))
		else $error("result presented outside the done state");

endmodule
